[rtl/veg_pkg.sv]
// Package for the vertex elimination graph block.
// Holds the operation codes, the sequencer states, the register map and the
// shared population count. No dependencies.
package veg_pkg;

	typedef enum logic [2:0] {
		OP_ADD_EDGE  = 3'd0,
		OP_ELIMINATE = 3'd1,
		OP_QUERY     = 3'd2,
		OP_ROLLBACK  = 3'd3,
		OP_CLEAR     = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_ROW_A,
		ST_SWEEP,
		ST_COPY,
		ST_FINISH
	} state_t;

	localparam logic       REG_VERTEX_COUNT   = 1'b0;
	localparam logic [5:0] VERTEX_COUNT_RESET = 6'd32;

	function automatic logic [6:0] popcount64(input logic [63:0] x);
		logic [6:0] c;
		c = '0;
		for (int i = 0; i < 64; i++) begin
			c = c + 7'(x[i]);
		end
		return c;
	endfunction

endpackage

[rtl/veg_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module veg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/vertex_elimination_graph.sv]
// Vertex elimination graph: top level with sequencer, row datapath and APB register.
// Depends on veg_pkg and veg_ram (current and original adjacency matrices).
//
// Usage: a transaction is taken when start is high and busy is low; operation,
// vertex_a and vertex_b are sampled then. Exactly one result follows, shown on
// live_degree, fill_count, remaining and bad_vertex for the single cycle in which
// done is high. The receiver cannot hold a result off.
// Steps from acceptance until done rises: eliminate and query read one row,
// then one row of the adjacency RAM per cycle through the shared row unit;
// rollback copies rows from the original RAM; add edge does a read-modify-write
// of both endpoint rows; clear, rejected and unknown operations, a repeated
// eliminate and a self-edge go straight to the finish state. The next transaction
// is accepted at the earliest at the edge that ends the done cycle.
// The vertex_count register sits at byte address 0 of the APB port. The user must
// write it only while the block is idle; the block itself does not enforce this.
// Reset empties both graphs at once through per-row valid bits, clears the
// eliminated flags and the elimination count and sets vertex_count to 32.
module vertex_elimination_graph #(
	parameter int MAX_VERTICES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [4:0]  vertex_a,
	input  logic [4:0]  vertex_b,
	output logic        done,
	output logic [4:0]  live_degree,
	output logic [8:0]  fill_count,
	output logic [5:0]  remaining,
	output logic        bad_vertex,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import veg_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int CW = (NW > 6) ? NW : 6;
	localparam logic [AW-1:0]           LAST_ROW = AW'(MAX_VERTICES - 1);
	localparam logic [CW-1:0]           MAX_N    = CW'(MAX_VERTICES);
	localparam logic [MAX_VERTICES-1:0] ONE_HOT0 = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	state_t state_q, state_d;
	op_t    op_q;

	logic [5:0]              vertex_count_q;
	logic [5:0]              elim_cnt_q;
	logic [CW-1:0]           n_eff;
	logic [MAX_VERTICES-1:0] live, higher, elim_q, cur_vld_q, org_vld_q;
	logic [MAX_VERTICES-1:0] nb_q, nb_row, row_cur, row_org, pop_mask;
	logic [MAX_VERTICES-1:0] a_bit, b_bit, k_bit;
	logic [MAX_VERTICES-1:0] cur_wdata, org_wdata, cur_rdata, org_rdata;
	logic [4:0]              a_q, b_q;
	logic [AW-1:0]           a_idx, b_idx, in_a_idx, k_q, raddr, raddr_q, waddr;
	logic                    cur_we, org_we;
	logic                    accept, in_bad, a_out, b_out, last_row;
	logic [6:0]              pop;
	logic [4:0]              deg_q;
	logic [8:0]              fill_q;
	logic                    bad_q;
	logic [5:0]              rem;
	logic                    done_q;
	logic [4:0]              live_degree_q;
	logic [8:0]              fill_count_q;
	logic [5:0]              remaining_q;
	logic                    bad_vertex_q;

	veg_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (waddr),
		.wdata (cur_wdata),
		.raddr (raddr),
		.rdata (cur_rdata)
	);

	veg_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_org_ram (
		.clk   (clk),
		.we    (org_we),
		.waddr (waddr),
		.wdata (org_wdata),
		.raddr (raddr),
		.rdata (org_rdata)
	);

	assign n_eff = (CW'(vertex_count_q) < MAX_N) ? CW'(vertex_count_q) : MAX_N;

	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_masks
		assign live[k]   = (CW'(k) < n_eff) && !elim_q[k];
		assign higher[k] = (AW'(k) > k_q);
	end

	assign accept   = start && (state_q == ST_IDLE);
	assign in_a_idx = AW'(vertex_a);
	assign a_idx    = AW'(a_q);
	assign b_idx    = AW'(b_q);
	assign a_bit    = ONE_HOT0 << a_idx;
	assign b_bit    = ONE_HOT0 << b_idx;
	assign k_bit    = ONE_HOT0 << k_q;
	assign last_row = (k_q == LAST_ROW);

	assign row_cur = cur_rdata & {MAX_VERTICES{cur_vld_q[raddr_q]}};
	assign row_org = org_rdata & {MAX_VERTICES{org_vld_q[raddr_q]}};
	assign nb_row  = row_cur & live & ~a_bit;

	// One population count serves both the degree and every fill term.
	assign pop_mask = (state_q == ST_ROW_A) ? nb_row : (nb_q & higher & ~row_cur);
	assign pop      = popcount64(64'(pop_mask));

	assign a_out = (CW'(vertex_a) >= n_eff);
	assign b_out = (CW'(vertex_b) >= n_eff);

	always_comb begin
		unique case (operation) inside
			OP_ADD_EDGE:             in_bad = a_out || b_out;
			OP_ELIMINATE, OP_QUERY:  in_bad = a_out;
			default:                 in_bad = 1'b0;
		endcase
	end

	assign rem = (n_eff > CW'(elim_cnt_q)) ? 6'(n_eff - CW'(elim_cnt_q)) : 6'd0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (in_bad) begin
						state_d = ST_FINISH;
					end else begin
						unique case (operation)
							OP_ADD_EDGE:  state_d = (vertex_a == vertex_b) ? ST_FINISH : ST_EDGE_A;
							OP_ELIMINATE: state_d = elim_q[in_a_idx] ? ST_FINISH : ST_ROW_A;
							OP_QUERY:     state_d = ST_ROW_A;
							OP_ROLLBACK:  state_d = ST_COPY;
							default:      state_d = ST_FINISH;
						endcase
					end
				end
			end
			ST_EDGE_A: state_d = ST_EDGE_B;
			ST_EDGE_B: state_d = ST_FINISH;
			ST_ROW_A:  state_d = ST_SWEEP;
			ST_SWEEP:  state_d = last_row ? ST_FINISH : ST_SWEEP;
			ST_COPY:   state_d = last_row ? ST_FINISH : ST_COPY;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		raddr     = '0;
		waddr     = '0;
		cur_we    = 1'b0;
		org_we    = 1'b0;
		cur_wdata = '0;
		org_wdata = '0;
		unique case (state_q)
			ST_IDLE: begin
				raddr = (operation == OP_ROLLBACK) ? '0 : in_a_idx;
			end
			ST_EDGE_A: begin
				raddr     = b_idx;
				waddr     = a_idx;
				cur_we    = 1'b1;
				org_we    = 1'b1;
				cur_wdata = row_cur | b_bit;
				org_wdata = row_org | b_bit;
			end
			ST_EDGE_B: begin
				waddr     = b_idx;
				cur_we    = 1'b1;
				org_we    = 1'b1;
				cur_wdata = row_cur | a_bit;
				org_wdata = row_org | a_bit;
			end
			ST_ROW_A: begin
				raddr = '0;
			end
			ST_SWEEP: begin
				raddr = k_q + AW'(1);
				waddr = k_q;
				if (op_q == OP_ELIMINATE) begin
					cur_we = 1'b1;
					if (k_q == a_idx) begin
						cur_wdata = '0;
					end else if (nb_q[k_q]) begin
						cur_wdata = (row_cur | (nb_q & ~k_bit)) & ~a_bit;
					end else begin
						cur_wdata = row_cur & ~a_bit;
					end
				end
			end
			ST_COPY: begin
				raddr     = k_q + AW'(1);
				waddr     = k_q;
				cur_we    = 1'b1;
				cur_wdata = row_org;
			end
			ST_FINISH: begin
				raddr = '0;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_count_q <= VERTEX_COUNT_RESET;
			elim_q         <= '0;
			elim_cnt_q     <= '0;
			cur_vld_q      <= '0;
			org_vld_q      <= '0;
			k_q            <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
			if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT)) begin
				vertex_count_q <= pwdata[5:0];
			end
			if (cur_we) begin
				cur_vld_q[waddr] <= 1'b1;
			end
			if (org_we) begin
				org_vld_q[waddr] <= 1'b1;
			end
			if (accept) begin
				k_q <= '0;
				case (operation)
					OP_ROLLBACK: begin
						elim_q     <= '0;
						elim_cnt_q <= '0;
					end
					OP_CLEAR: begin
						elim_q     <= '0;
						elim_cnt_q <= '0;
						cur_vld_q  <= '0;
						org_vld_q  <= '0;
					end
					default: begin
					end
				endcase
			end
			if ((state_q == ST_SWEEP) || (state_q == ST_COPY)) begin
				k_q <= k_q + AW'(1);
			end
			if ((state_q == ST_SWEEP) && last_row && (op_q == OP_ELIMINATE)) begin
				elim_q[a_idx] <= 1'b1;
				elim_cnt_q    <= elim_cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_q <= raddr;
		if (accept) begin
			op_q   <= op_t'(operation);
			a_q    <= vertex_a;
			b_q    <= vertex_b;
			bad_q  <= in_bad;
			deg_q  <= '0;
			fill_q <= '0;
		end
		if (state_q == ST_ROW_A) begin
			nb_q <= nb_row;
			if (op_q == OP_QUERY) begin
				deg_q <= pop[4:0];
			end
		end
		if ((state_q == ST_SWEEP) && (op_q == OP_QUERY) && nb_q[k_q]) begin
			fill_q <= fill_q + 9'(pop);
		end
		if (state_q == ST_FINISH) begin
			live_degree_q <= deg_q;
			fill_count_q  <= fill_q;
			remaining_q   <= rem;
			bad_vertex_q  <= bad_q;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign live_degree = live_degree_q;
	assign fill_count  = fill_count_q;
	assign remaining   = remaining_q;
	assign bad_vertex  = bad_vertex_q;
	assign pready      = 1'b1;
	assign prdata      = (paddr[2] == REG_VERTEX_COUNT) ? {26'd0, vertex_count_q} : 32'd0;

endmodule

[rtl/veg_checker.sv]
// Port-level checker for the vertex elimination graph block, and its binding.
// Depends only on the top level's ports.
module veg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [4:0] live_degree,
	input logic [8:0] fill_count,
	input logic       bad_vertex
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted transaction did not make the block busy.");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("Result appeared without a transaction in progress.");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_vertex |-> (live_degree == 5'd0) && (fill_count == 9'd0))
		else $error("Rejected transaction reported a non-zero degree or fill.");

endmodule

bind vertex_elimination_graph veg_checker u_veg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.live_degree (live_degree),
	.fill_count  (fill_count),
	.bad_vertex  (bad_vertex)
);
